FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define IWO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define IWO_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/iwo_pkg.sv
// shared types, widths and constants of the wavetable oscillator voice
package iwo_pkg;

    localparam int DEFAULT_TABLE_SIZE = 1024;
    localparam int FRAC_W = 16;
    localparam int ADDR_FIELD_W = 10;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W = 24;
    localparam int GAIN_W = 16;
    localparam int TUNE_W = 24;

    // stream widths: input fields fill 98 bits, padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 24;

    // input tdata field positions
    localparam int ADDR_LSB = 0;
    localparam int VALUE_LSB = ADDR_LSB + ADDR_FIELD_W;
    localparam int RATE_LSB = VALUE_LSB + SAMPLE_W;
    localparam int MOD_LSB = RATE_LSB + SAMPLE_W;
    localparam int SYNC_LSB = MOD_LSB + SAMPLE_W;
    localparam int ACC_LSB = SYNC_LSB + SAMPLE_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;
    localparam logic signed [TUNE_W-1:0] TUNE_RESET = 24'sd65536;
    localparam logic signed [SAMPLE_W-1:0] MOD_DEPTH_RESET = 16'sd0;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_WRITE  = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN      = 2'd0,
        REG_TUNE      = 2'd1,
        REG_MOD_DEPTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]          gain;
        logic signed [TUNE_W-1:0]   tune;
        logic signed [SAMPLE_W-1:0] mod_depth;
    } cfg_t;

    // one classified request as it waits in the queue
    typedef struct packed {
        kind_t                      kind;
        logic [ADDR_FIELD_W-1:0]    table_addr;
        logic signed [SAMPLE_W-1:0] table_value;
        logic signed [SAMPLE_W-1:0] rate_in;
        logic signed [SAMPLE_W-1:0] mod_in;
        logic                       sync_neg;
        logic signed [ACC_W-1:0]    acc_in;
    } item_t;

endpackage

FILE: rtl/core/interp_wavetable_osc_sync.sv
// top level of the wavetable oscillator voice with linear interpolation and hard sync
//
// usage
// - input stream (s_*): each request is either a table word write (s_tuser = 1) or one
//   audio sample (s_tuser = 0); a write gives no result, a sample gives one result
// - output stream (m_*): one 24-bit saturated mix sample per sample request, in order
// - config port: cfg_we with cfg_index 0 gain, 1 tune, 2 mod_depth; write only while idle
// - the four-step sequencer (interp, sum, gain, out) takes one sample at a time; the next
//   request is popped in the out step once the output register is free, and a table
//   write is done while the sequencer is idle or in its out step
// - the table memory has one write and two read ports, read data registered
// - TABLE_SIZE must be a power of two from 16 to 65536; writes at or above it are dropped
// - reset clears phase, sync history, queue and output register and restores the
//   register defaults; the table is not cleared, so fill it before running samples
// - when the receiver stalls, the result waits in the output register, the sequencer
//   holds in its last step and the 2-deep request queue fills before s_tready drops
module interp_wavetable_osc_sync #(
    parameter int TABLE_SIZE = iwo_pkg::DEFAULT_TABLE_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // table_addr[9:0], table_value[25:10], rate_in[41:26], mod_in[57:42],
    // sync_in[73:58], acc_in[97:74], zero pad [103:98]
    input  logic [iwo_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic [0:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_sample[23:0]
    output logic [iwo_pkg::M_TDATA_W-1:0]   m_tdata,
    // register writes
    input  logic                            cfg_we,
    input  logic [iwo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [iwo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import iwo_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // register file, taken whole by the back end
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN:      cfg_next.gain      = cfg_data[GAIN_W-1:0];
                REG_TUNE:      cfg_next.tune      = cfg_data[TUNE_W-1:0];
                REG_MOD_DEPTH: cfg_next.mod_depth = cfg_data[SAMPLE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.tune      <= TUNE_RESET;
            cfg_reg.mod_depth <= MOD_DEPTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: unpack and classify requests
    iwo_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // queue lets intake run ahead of the sequencer
    iwo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: table memory, interpolation, phase update, output register
    iwo_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/core/iwo_queue.sv
// short request queue between the front and the back of the voice
module iwo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  iwo_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output iwo_pkg::item_t head_item
);
    import iwo_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/iwo_front.sv
// request intake: unpacks the stream, classifies it and drops out-of-range writes
module iwo_front #(
    parameter int TABLE_SIZE = iwo_pkg::DEFAULT_TABLE_SIZE
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iwo_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          q_full,
    output logic                          push,
    output iwo_pkg::item_t                push_item
);
    import iwo_pkg::*;

    localparam int PAD_W = 32 - ADDR_FIELD_W;

    logic addr_ok;

    always_comb
    begin
        push_item.kind        = kind_t'(s_tuser[0]);
        push_item.table_addr  = s_tdata[ADDR_LSB +: ADDR_FIELD_W];
        push_item.table_value = s_tdata[VALUE_LSB +: SAMPLE_W];
        push_item.rate_in     = s_tdata[RATE_LSB +: SAMPLE_W];
        push_item.mod_in      = s_tdata[MOD_LSB +: SAMPLE_W];
        // only the sign of the sync sample is kept
        push_item.sync_neg    = s_tdata[SYNC_LSB + SAMPLE_W - 1];
        push_item.acc_in      = s_tdata[ACC_LSB +: ACC_W];
    end

    assign addr_ok  = ({{PAD_W{1'b0}}, push_item.table_addr} < 32'(TABLE_SIZE));
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && ((push_item.kind == KIND_SAMPLE) || addr_ok);

endmodule

FILE: rtl/core/iwo_back.sv
// execution side: wave table memory, interpolation sequencer, phase and output register
module iwo_back #(
    parameter int TABLE_SIZE = iwo_pkg::DEFAULT_TABLE_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iwo_pkg::cfg_t                 cfg,
    input  logic                          head_valid,
    input  iwo_pkg::item_t                head_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iwo_pkg::M_TDATA_W-1:0] m_tdata
);
    import iwo_pkg::*;

    localparam int ADDR_W   = $clog2(TABLE_SIZE);
    localparam int PH_W     = ADDR_W + FRAC_W;
    localparam int RT_W     = SAMPLE_W + TUNE_W;
    localparam int MD_W     = 2 * SAMPLE_W;
    localparam int STEP_SH  = 11;
    localparam int S_W      = RT_W + 3;
    localparam int STEP_W   = S_W - STEP_SH;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int MIF_W    = 2 * DIFF_W;
    localparam int INTERP_W = MIF_W + 1;
    localparam int GPROD_W  = INTERP_W + GAIN_W + 1;
    localparam int RND_SH   = 31;
    localparam int TERM_W   = GPROD_W - RND_SH;
    localparam int SUM_W    = ACC_W + 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_INTERP = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_GAIN   = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [SAMPLE_W-1:0] table_mem [TABLE_SIZE];

    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   phase_next;
    logic              last_sync_neg_reg;
    logic              last_sync_neg_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ACC_W-1:0]  out_data_reg;

    logic signed [SAMPLE_W-1:0] rd_a_reg;
    logic signed [SAMPLE_W-1:0] rd_b_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       rising_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [RT_W-1:0]     rt_reg;
    logic signed [MD_W-1:0]     md_reg;
    logic signed [MIF_W-1:0]    mif_reg;
    logic signed [STEP_W-1:0]   step_reg;
    logic signed [INTERP_W-1:0] interp_reg;
    logic signed [GPROD_W-1:0]  gprod_reg;

    logic              out_free;
    logic              pop_sample;
    logic              pop_write;
    logic              rising;
    logic [ADDR_W-1:0] rd_idx_a;
    logic [ADDR_W-1:0] rd_idx_b;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   frac_s;
    logic signed [S_W-1:0]      step_full;
    logic signed [INTERP_W-1:0] interp_sum;
    logic signed [DIFF_W-1:0]   gain_s;
    logic [PH_W-1:0]            phase_adv;
    logic signed [TERM_W-1:0]   term;
    logic signed [SUM_W-1:0]    mix_sum;
    logic [ACC_W-1:0]           mix_sat;

    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = head_valid && ((state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_free));
    assign pop_sample = pop && (head_item.kind == KIND_SAMPLE);
    assign pop_write  = pop && (head_item.kind == KIND_WRITE);

    // rising sync: previous sample negative, this one not
    assign rising   = last_sync_neg_reg && !head_item.sync_neg;
    assign rd_idx_a = phase_reg[PH_W-1:FRAC_W];
    // power-of-two table: the last entry wraps to entry 0 by itself
    assign rd_idx_b = rising ? '0 : rd_idx_a + 1'b1;

    always_ff @(posedge clk)
    begin
        if (pop_write)
        begin
            table_mem[ADDR_W'(head_item.table_addr)] <= head_item.table_value;
        end
        if (pop_sample)
        begin
            rd_a_reg <= table_mem[rd_idx_a];
            rd_b_reg <= table_mem[rd_idx_b];
        end
    end

    // datapath arithmetic
    assign diff       = DIFF_W'(rd_b_reg) - DIFF_W'(rd_a_reg);
    assign frac_s     = {1'b0, frac_reg};
    assign step_full  = (S_W'(rt_reg) <<< 2) + S_W'(md_reg);
    assign interp_sum = (INTERP_W'(rd_a_reg) <<< FRAC_W) + INTERP_W'(mif_reg);
    assign gain_s     = {1'b0, cfg.gain};
    assign phase_adv  = PH_W'(STEP_W'(phase_reg) + step_reg);

    // round half up: bit below the cut is the carry in
    assign term    = gprod_reg[GPROD_W-1:RND_SH];
    assign mix_sum = SUM_W'(acc_reg) + SUM_W'(term) + SUM_W'(gprod_reg[RND_SH-1]);

    always_comb
    begin
        if (!mix_sum[SUM_W-1] && (mix_sum[SUM_W-2:ACC_W-1] != '0))
        begin
            mix_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (mix_sum[SUM_W-1] && (mix_sum[SUM_W-2:ACC_W-1] != '1))
        begin
            mix_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            mix_sat = mix_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_sample)
        begin
            frac_reg   <= phase_reg[FRAC_W-1:0];
            rising_reg <= rising;
            acc_reg    <= head_item.acc_in;
            rt_reg     <= head_item.rate_in * cfg.tune;
            md_reg     <= head_item.mod_in * cfg.mod_depth;
        end
        if (state_reg == ST_INTERP)
        begin
            mif_reg  <= diff * frac_s;
            step_reg <= step_full[S_W-1:STEP_SH];
        end
        if (state_reg == ST_SUM)
        begin
            interp_reg <= interp_sum;
        end
        if (state_reg == ST_GAIN)
        begin
            // zero gain: the mix passes through untouched, whatever the table holds
            if (cfg.gain == '0)
            begin
                gprod_reg <= '0;
            end
            else
            begin
                gprod_reg <= interp_reg * gain_s;
            end
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_data_reg <= mix_sat;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        last_sync_neg_next = last_sync_neg_reg;
        out_valid_next     = out_valid_reg;

        if (pop_sample)
        begin
            last_sync_neg_next = head_item.sync_neg;
        end

        // phase settles before the next request can be popped
        if ((state_reg == ST_SUM) && (cfg.gain != '0))
        begin
            phase_next = rising_reg ? {{ADDR_W{1'b0}}, frac_reg} : phase_adv;
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_sample)
                begin
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = pop_sample ? ST_INTERP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= '0;
            last_sync_neg_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            last_sync_neg_reg <= last_sync_neg_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/iwo_checker.sv
// port-level checks of the oscillator voice and their binding to the top level
`include "assert_macros.svh"

module iwo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [iwo_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    `IWO_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // results leave the sequencer one at a time, each after its interp, sum, gain and out steps,
    // and one waits in the output register, so at most two transfers can come in a row
    `IWO_ASSERT(a_out_spacing, clk, rst_n, (m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |=> !(m_tvalid && m_tready), "results closer than the sequencer allows")

    // the queue only fills on an accepted request
    `IWO_ASSERT(a_ready_drop, clk, rst_n, $fell(s_tready) |-> $past(s_tvalid && s_tready), "s_tready dropped without a request")

    // no result earlier than the pipeline latency after reset release
    `IWO_ASSERT_NORST(a_reset_latency, clk, $rose(m_tvalid) |-> $past(rst_n, 5), "result too soon after reset")

endmodule

bind interp_wavetable_osc_sync iwo_checker u_iwo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
